FILE: hw/rtl/per_cpu_page_free_list_allocator_assert.svh
// Assertion macros for the per-CPU page allocator.
// Used by pcpa_ctrl and pcpa_dp; define NO_ASSERTIONS to compile them out.
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PCPA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pcpa assertion failed");
`define PCPA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("pcpa forbidden condition seen");
`else
`define PCPA_ASSERT(lbl, clk, rst_n, prop)
`define PCPA_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: hw/rtl/pcpa_pkg.sv
// Shared types and constants for the per-CPU page allocator.
// No dependencies; used by pcpa_ctrl, pcpa_dp and the top level.
`default_nettype none

package pcpa_pkg;

  localparam int unsigned HEAD_W    = 16;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned CPU_W     = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [HEAD_W-1:0] EMPTY_MARK = 16'hFFFF;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_TOP     = 2'd2;

  localparam logic [ADDR_W-1:0] RST_REGION_BASE = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] RST_KERNEL_END  = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] RST_MEM_TOP     = 32'h8800_0000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } pcpa_state_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic pop;
  } pcpa_cmd_t;

  typedef struct packed {
    logic is_free;
    logic alloc_hit;
  } pcpa_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pcpa_ctrl.sv
// Sequencer for the per-CPU page allocator: idle, execute, pop.
// Depends on pcpa_pkg and the assertion macro header.
`default_nettype none

`include "per_cpu_page_free_list_allocator_assert.svh"

module pcpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  pcpa_pkg::pcpa_sts_t  sts_i,
  output pcpa_pkg::pcpa_cmd_t  cmd_o,
  output logic                 busy
);

  pcpa_pkg::pcpa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcpa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pcpa_pkg::S_IDLE: begin
        if (start) state_d = pcpa_pkg::S_EXEC;
      end
      pcpa_pkg::S_EXEC: begin
        if (!sts_i.is_free && sts_i.alloc_hit) state_d = pcpa_pkg::S_POP;
        else state_d = pcpa_pkg::S_IDLE;
      end
      pcpa_pkg::S_POP: begin
        state_d = pcpa_pkg::S_IDLE;
      end
      default: begin
        state_d = pcpa_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      pcpa_pkg::S_IDLE: begin
        busy        = 1'b0;
        cmd_o.latch = start;
      end
      pcpa_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      pcpa_pkg::S_POP: begin
        cmd_o.pop = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  `PCPA_ASSERT(a_accept_to_exec, clk_i, rst_ni,
    (state_q == pcpa_pkg::S_IDLE && start) |=> state_q == pcpa_pkg::S_EXEC)
  `PCPA_ASSERT(a_pop_returns_idle, clk_i, rst_ni,
    state_q == pcpa_pkg::S_POP |=> state_q == pcpa_pkg::S_IDLE)
  `PCPA_ASSERT(a_pop_after_alloc_exec, clk_i, rst_ni,
    state_q == pcpa_pkg::S_POP |->
      ($past(state_q) == pcpa_pkg::S_EXEC && !$past(sts_i.is_free)))

endmodule

`default_nettype wire

FILE: hw/rtl/pcpa_dp.sv
// Datapath of the per-CPU page allocator: config registers, list heads,
// next-page link memory and result registers. Depends on pcpa_pkg.
`default_nettype none

`include "per_cpu_page_free_list_allocator_assert.svh"

module pcpa_dp #(
  parameter int unsigned CPUS       = 8,
  parameter int unsigned PAGES      = 32768,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pcpa_pkg::pcpa_cmd_t                  cmd_i,
  output pcpa_pkg::pcpa_sts_t                  sts_o,
  input  logic                                 action_i,
  input  logic [pcpa_pkg::CPU_W-1:0]           cpu_i,
  input  logic [pcpa_pkg::ADDR_W-1:0]          page_addr_i,
  input  logic                                 cfg_we_i,
  input  logic [pcpa_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pcpa_pkg::ADDR_W-1:0]          cfg_wdata_i,
  output logic                                 done_o,
  output logic [pcpa_pkg::STATUS_W-1:0]        status_o,
  output logic [pcpa_pkg::ADDR_W-1:0]          alloc_addr_o,
  output logic [pcpa_pkg::CPU_W-1:0]           source_cpu_o
);

  localparam int unsigned PB_LOG = $clog2(PAGE_BYTES);
  localparam int unsigned AW     = $clog2(PAGES);
  localparam int unsigned CIW    = (CPUS > 1) ? $clog2(CPUS) : 1;
  localparam int unsigned IDX_W  = pcpa_pkg::ADDR_W - PB_LOG;

  logic                               action_q;
  logic [pcpa_pkg::CPU_W-1:0]         cpu_q;
  logic [pcpa_pkg::ADDR_W-1:0]        addr_q;
  logic [pcpa_pkg::ADDR_W-1:0]        base_q, kend_q, mtop_q;
  logic [pcpa_pkg::HEAD_W-1:0]        head_q [CPUS];
  logic [pcpa_pkg::HEAD_W-1:0]        link_mem [PAGES];
  logic [pcpa_pkg::HEAD_W-1:0]        link_q;
  logic [pcpa_pkg::HEAD_W-1:0]        page_q;
  logic [CIW-1:0]                     sel_q;
  logic                               done_q;
  logic [pcpa_pkg::STATUS_W-1:0]      status_q;
  logic [pcpa_pkg::ADDR_W-1:0]        alloc_addr_q;
  logic [pcpa_pkg::CPU_W-1:0]         src_q;

  logic                               cpu_ok;
  logic [CIW-1:0]                     cpu_idx;
  logic [CPUS-1:0]                    nonempty;
  logic [CIW-1:0]                     low_idx;
  logic                               found;
  logic [CIW-1:0]                     sel;
  logic                               alloc_hit;
  logic [CIW-1:0]                     head_ridx;
  logic [pcpa_pkg::HEAD_W-1:0]        head_rd;
  logic [pcpa_pkg::ADDR_W-1:0]        diff;
  logic [IDX_W-1:0]                   page_idx;
  logic                               free_ok;
  logic                               is_free;
  logic                               free_wr;
  logic                               alloc_rd;
  logic                               finish_exec;

  assign is_free = (action_q == pcpa_pkg::ACT_FREE);
  assign cpu_ok  = (32'(cpu_q) < CPUS);
  assign cpu_idx = CIW'(cpu_q);

  always_comb begin
    for (int i = 0; i < CPUS; i++) begin
      nonempty[i] = (head_q[i] != pcpa_pkg::EMPTY_MARK) && (32'(head_q[i]) < PAGES);
    end
  end

  always_comb begin
    low_idx = '0;
    found   = 1'b0;
    for (int i = 0; i < CPUS; i++) begin
      if (!found && nonempty[i]) begin
        low_idx = CIW'(i);
        found   = 1'b1;
      end
    end
  end

  assign alloc_hit = |nonempty;
  assign sel       = (cpu_ok && nonempty[cpu_idx]) ? cpu_idx : low_idx;
  assign head_ridx = is_free ? cpu_idx : sel;
  assign head_rd   = head_q[head_ridx];

  assign diff     = addr_q - base_q;
  assign page_idx = diff[pcpa_pkg::ADDR_W-1:PB_LOG];
  assign free_ok  = !(|addr_q[PB_LOG-1:0]) && !(|diff[PB_LOG-1:0])
                    && !(addr_q < kend_q) && (addr_q < mtop_q)
                    && !(addr_q < base_q) && cpu_ok
                    && (32'(page_idx) < PAGES);

  assign free_wr     = cmd_i.exec && is_free && free_ok;
  assign alloc_rd    = cmd_i.exec && !is_free && alloc_hit;
  assign finish_exec = cmd_i.exec && (is_free || !alloc_hit);

  assign sts_o.is_free   = is_free;
  assign sts_o.alloc_hit = alloc_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= pcpa_pkg::RST_REGION_BASE;
      kend_q <= pcpa_pkg::RST_KERNEL_END;
      mtop_q <= pcpa_pkg::RST_MEM_TOP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcpa_pkg::CFG_REGION_BASE: base_q <= cfg_wdata_i;
        pcpa_pkg::CFG_KERNEL_END:  kend_q <= cfg_wdata_i;
        pcpa_pkg::CFG_MEM_TOP:     mtop_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      action_q <= action_i;
      cpu_q    <= cpu_i;
      addr_q   <= page_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CPUS; i++) begin
        head_q[i] <= pcpa_pkg::EMPTY_MARK;
      end
    end else if (free_wr) begin
      head_q[cpu_idx] <= pcpa_pkg::HEAD_W'(page_idx);
    end else if (cmd_i.pop) begin
      head_q[sel_q] <= link_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_wr) begin
      link_mem[page_idx[AW-1:0]] <= head_rd;
    end
    if (alloc_rd) begin
      link_q <= link_mem[head_rd[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc_rd) begin
      sel_q  <= sel;
      page_q <= head_rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= finish_exec || cmd_i.pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_exec) begin
      if (is_free) status_q <= free_ok ? pcpa_pkg::STATUS_OK : pcpa_pkg::STATUS_BAD;
      else status_q <= pcpa_pkg::STATUS_EMPTY;
      alloc_addr_q <= '0;
      src_q        <= '0;
    end else if (cmd_i.pop) begin
      status_q     <= pcpa_pkg::STATUS_OK;
      alloc_addr_q <= base_q + (pcpa_pkg::ADDR_W'(page_q) << PB_LOG);
      src_q        <= pcpa_pkg::CPU_W'(sel_q);
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign alloc_addr_o = alloc_addr_q;
  assign source_cpu_o = src_q;

  `PCPA_ASSERT(a_done_single_cycle, clk_i, rst_ni, done_q |=> !done_q)
  `PCPA_ASSERT(a_fail_has_zero_payload, clk_i, rst_ni,
    (done_q && status_q != pcpa_pkg::STATUS_OK) |-> (alloc_addr_q == '0 && src_q == '0))
  `PCPA_ASSERT_NEVER(a_no_write_and_read, clk_i, rst_ni, free_wr && alloc_rd)

endmodule

`default_nettype wire

FILE: hw/rtl/per_cpu_page_free_list_allocator.sv
// Top level of the per-CPU page allocator with list stealing.
// Instantiates pcpa_ctrl and pcpa_dp; depends on pcpa_pkg.
//
// An item is taken when start is high and busy is low. A free, and an
// allocation that finds every list empty, goes through the execute state;
// an allocation that finds a page also passes through the pop state, as the
// successor link of the popped page is read from the synchronous next-page
// memory before the list head is updated. Each item yields one result,
// shown for exactly one cycle with done_o high; the receiver cannot stall
// it, and busy drops in that same cycle so the next item can start.
// Configuration writes are always ready and must only be issued while idle.
`default_nettype none

module per_cpu_page_free_list_allocator #(
  parameter int unsigned CPUS       = 8,
  parameter int unsigned PAGES      = 32768,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 action_i,
  input  logic [pcpa_pkg::CPU_W-1:0]           cpu_i,
  input  logic [pcpa_pkg::ADDR_W-1:0]          page_addr_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pcpa_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pcpa_pkg::ADDR_W-1:0]          cfg_wdata_i,
  output logic                                 done_o,
  output logic [pcpa_pkg::STATUS_W-1:0]        status_o,
  output logic [pcpa_pkg::ADDR_W-1:0]          alloc_addr_o,
  output logic [pcpa_pkg::CPU_W-1:0]           source_cpu_o
);

  pcpa_pkg::pcpa_cmd_t cmd;
  pcpa_pkg::pcpa_sts_t sts;

  assign cfg_ready_o = 1'b1;

  pcpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  pcpa_dp #(
    .CPUS       (CPUS),
    .PAGES      (PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .action_i     (action_i),
    .cpu_i        (cpu_i),
    .page_addr_i  (page_addr_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .alloc_addr_o (alloc_addr_o),
    .source_cpu_o (source_cpu_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/per_cpu_page_free_list_allocator_tb.sv
// Self-checking bench for the per-CPU page allocator: directed and random frees and allocs,
// checked against an in-bench model of the per-CPU free lists and the stealing order.
// Depends on pcpa_pkg and per_cpu_page_free_list_allocator.
module per_cpu_page_free_list_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcpa_pkg::*;

  localparam int unsigned CPU_COUNT    = 8;
  localparam int unsigned PAGE_COUNT   = 32768;
  localparam int unsigned PAGE_SIZE    = 4096;
  localparam int          RANDOM_ITEMS = 1500;
  localparam int          SETTLE       = 4;
  localparam int          CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
    logic [CPU_W-1:0]    src;
  } page_result_t;

  class page_list_tracker;
    logic [ADDR_W-1:0] region_base;
    logic [ADDR_W-1:0] kernel_end;
    logic [ADDR_W-1:0] mem_top;
    logic [HEAD_W-1:0] head [CPU_COUNT];
    logic [HEAD_W-1:0] link [PAGE_COUNT];
    bit                listed [PAGE_COUNT];
    page_result_t      pending_results [$];
    int n_items, n_errors, n_rejected, n_empty, n_granted, n_stolen, n_settings;

    function new();
      region_base = RST_REGION_BASE;
      kernel_end  = RST_KERNEL_END;
      mem_top     = RST_MEM_TOP;
      foreach (head[i]) head[i] = EMPTY_MARK;
      n_settings = 1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      case (idx)
        CFG_REGION_BASE: region_base = data;
        CFG_KERNEL_END:  kernel_end  = data;
        CFG_MEM_TOP:     mem_top     = data;
        default: ;
      endcase
    endfunction

    function bit pop_head(int c, output logic [HEAD_W-1:0] page);
      page = head[c];
      if (page == EMPTY_MARK || page >= PAGE_COUNT) return 1'b0;
      head[c] = link[page];
      listed[page] = 1'b0;
      return 1'b1;
    endfunction

    function void take_item(logic act, logic [CPU_W-1:0] cpu, logic [ADDR_W-1:0] addr);
      page_result_t      r;
      logic [ADDR_W-1:0] offset;
      logic [HEAD_W-1:0] page;
      int                from;
      bit                got;
      r = '0;
      from = 0;
      got = 1'b0;
      if (act == ACT_FREE) begin
        offset = addr - region_base;
        if (addr % PAGE_SIZE != 0 || addr < kernel_end || addr >= mem_top ||
            addr < region_base || cpu >= CPU_COUNT || offset % PAGE_SIZE != 0 ||
            offset / PAGE_SIZE >= PAGE_COUNT) begin
          r.status = STATUS_BAD;
          n_rejected++;
        end else begin
          page = HEAD_W'(offset / PAGE_SIZE);
          link[page] = head[cpu];
          head[cpu] = page;
          listed[page] = 1'b1;
        end
      end else begin
        if (cpu < CPU_COUNT && pop_head(int'(cpu), page)) begin
          got = 1'b1;
          from = int'(cpu);
        end else begin
          for (int i = 0; i < CPU_COUNT; i++) begin
            if (i != int'(cpu) && !got && pop_head(i, page)) begin
              got = 1'b1;
              from = i;
            end
          end
        end
        if (got) begin
          r.addr = region_base + ADDR_W'(32'(page) * PAGE_SIZE);
          r.src = CPU_W'(from);
          n_granted++;
          if (from != int'(cpu)) n_stolen++;
        end else begin
          r.status = STATUS_EMPTY;
          n_empty++;
        end
      end
      pending_results.push_back(r);
      n_items++;
    endfunction

    function void match_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] addr,
                               logic [CPU_W-1:0] src);
      page_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d addr %h source %0d",
                 $time, status, addr, src);
        n_errors++;
        return;
      end
      e = pending_results.pop_front();
      if (status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        n_errors++;
      end
      if (addr !== e.addr) begin
        $display("%0t: alloc_addr expected %h actual %h", $time, e.addr, addr);
        n_errors++;
      end
      if (src !== e.src) begin
        $display("%0t: source_cpu expected %0d actual %0d", $time, e.src, src);
        n_errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 action_i;
  logic [CPU_W-1:0]     cpu_i;
  logic [ADDR_W-1:0]    page_addr_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ADDR_W-1:0]    cfg_wdata_i;
  logic                 done_o;
  logic [STATUS_W-1:0]  status_o;
  logic [ADDR_W-1:0]    alloc_addr_o;
  logic [CPU_W-1:0]     source_cpu_o;

  page_list_tracker tracker = new();
  int idle_pct = 0;
  int random_done = 0;
  int cycle_count = 0;

  per_cpu_page_free_list_allocator #(
    .CPUS      (CPU_COUNT),
    .PAGES     (PAGE_COUNT),
    .PAGE_BYTES(PAGE_SIZE)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (action_i),
    .cpu_i       (cpu_i),
    .page_addr_i (page_addr_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .alloc_addr_o(alloc_addr_o),
    .source_cpu_o(source_cpu_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("per_cpu_page_free_list_allocator_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.match_result(status_o, alloc_addr_o, source_cpu_o);
  end

  task automatic send_item(input logic act, input logic [CPU_W-1:0] cpu,
                           input logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    action_i <= act;
    cpu_i <= cpu;
    page_addr_i <= addr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    tracker.take_item(act, cpu, addr);
    @(negedge clk_i);
  endtask

  // hold off until every pending result is back, then let the block settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] kend,
                           input logic [ADDR_W-1:0] top, input int count);
    longint            lo;
    longint            hi;
    bit                has_valid;
    bit                found;
    int                free_bias;
    int                page;
    int                pick;
    logic              act;
    logic [CPU_W-1:0]  cpu;
    logic [ADDR_W-1:0] addr;
    drain();
    write_cfg(CFG_REGION_BASE, base);
    write_cfg(CFG_KERNEL_END, kend);
    write_cfg(CFG_MEM_TOP, top);
    cfg_valid_i <= 1'b0;
    tracker.n_settings++;
    lo = 0;
    hi = 0;
    free_bias = 50;
    has_valid = (base % PAGE_SIZE == 0) && (top > base);
    if (has_valid) begin
      if (kend > base) lo = (longint'(kend) - longint'(base) + PAGE_SIZE - 1) / PAGE_SIZE;
      hi = (longint'(top) - longint'(base) + PAGE_SIZE - 1) / PAGE_SIZE - 1;
      if (hi > PAGE_COUNT - 1) hi = PAGE_COUNT - 1;
      has_valid = lo <= hi;
    end
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) free_bias = 25 * $urandom_range(3, 1);
      idle_pct = (random_done < RANDOM_ITEMS / 3) ? 16 :
                 (random_done < 2 * RANDOM_ITEMS / 3) ? 82 : 0;
      act = ACT_ALLOC;
      cpu = CPU_W'($urandom);
      addr = $urandom;
      if ($urandom_range(99) < 15) begin
        pick = $urandom_range(2);
        case ($urandom_range(3))
          0: act = 1'($urandom);
          1: begin
            act = ACT_FREE;
            addr = kend - PAGE_SIZE;
          end
          2: begin
            act = ACT_FREE;
            addr = (pick == 0) ? top : (pick == 1) ? base - PAGE_SIZE :
                   base + ADDR_W'(PAGE_COUNT * PAGE_SIZE);
          end
          default: begin
            act = ACT_FREE;
            addr = base + ADDR_W'($urandom_range(PAGE_COUNT - 1) * PAGE_SIZE +
                                  $urandom_range(PAGE_SIZE - 1, 1));
          end
        endcase
      end else if (has_valid && $urandom_range(99) < free_bias) begin
        found = 1'b0;
        for (int t = 0; t < 8 && !found; t++) begin
          page = int'($urandom_range(int'(hi), int'(lo)));
          found = !tracker.listed[page];
        end
        if (found) begin
          act = ACT_FREE;
          addr = base + ADDR_W'(page * PAGE_SIZE);
        end
      end
      send_item(act, cpu, addr);
      random_done++;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    action_i = ACT_ALLOC;
    cpu_i = '0;
    page_addr_i = '0;
    cfg_valid_i = 1'b0;
    cfg_idx_i = CFG_REGION_BASE;
    cfg_wdata_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(ACT_ALLOC, 3'd0, 32'h0000_0000);
    send_item(ACT_ALLOC, 3'd7, 32'hFFFF_FFFF);
    send_item(ACT_FREE,  3'd0, 32'h8000_0000);
    send_item(ACT_FREE,  3'd7, 32'h87FF_F000);
    send_item(ACT_FREE,  3'd3, 32'h8800_0000);
    send_item(ACT_FREE,  3'd3, 32'h7FFF_F000);
    send_item(ACT_FREE,  3'd1, 32'h8000_0001);
    send_item(ACT_FREE,  3'd1, 32'h8000_0800);
    send_item(ACT_FREE,  3'd2, 32'hFFFF_FFFF);
    send_item(ACT_FREE,  3'd2, 32'h0000_0000);
    send_item(ACT_FREE,  3'd0, 32'h8000_1000);
    send_item(ACT_ALLOC, 3'd0, 32'h0000_0000);
    send_item(ACT_ALLOC, 3'd3, 32'h0000_0000);
    send_item(ACT_ALLOC, 3'd3, 32'h0000_0000);
    send_item(ACT_ALLOC, 3'd5, 32'h0000_0000);
    send_item(ACT_FREE,  3'd1, 32'h8000_2000);
    send_item(ACT_FREE,  3'd2, 32'h8000_2000);
    send_item(ACT_ALLOC, 3'd1, 32'h0000_0000);
    send_item(ACT_ALLOC, 3'd2, 32'h0000_0000);
    send_item(ACT_FREE,  3'd6, 32'h8000_3000);
    send_item(ACT_FREE,  3'd6, 32'h8000_4000);
    send_item(ACT_ALLOC, 3'd6, 32'h0000_0000);
    send_item(ACT_ALLOC, 3'd4, 32'h0000_0000);
    send_item(ACT_ALLOC, 3'd4, 32'h0000_0000);

    run_phase(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 500);
    run_phase(32'hFFFF_8000, 32'hFFFF_A000, 32'hFFFF_FFFF, 350);
    run_phase(32'h1000_0800, 32'hFFFF_FFFF, 32'h0000_0000, 150);
    run_phase(32'h8000_0000, 32'h8004_0000, 32'h8010_0000, 500);
    drain();

    $display("%0d items over %0d register settings: %0d pages granted (%0d stolen),",
             tracker.n_items, tracker.n_settings, tracker.n_granted, tracker.n_stolen);
    $display("%0d allocs found every list empty, %0d frees rejected, %0d mismatches",
             tracker.n_empty, tracker.n_rejected, tracker.n_errors);
    if (tracker.n_errors == 0) begin
      $display("per_cpu_page_free_list_allocator_tb OK");
    end else begin
      $display("per_cpu_page_free_list_allocator_tb NOT OK");
    end
    $finish;
  end

endmodule
